// ----- hw/rtl/tmbl_pkg.sv -----
// Shared widths, action codes and register indexes for the memory budget ledger.
`default_nettype none

package tmbl_pkg;

    localparam int BYTES_W   = 40;
    localparam int TAG_IN_W  = 4;
    localparam int ACTION_W  = 3;
    localparam int REG_W     = 48;
    localparam int OUT_W     = 48;
    localparam int DEG_W     = 32;
    localparam int MASK_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [MASK_W-1:0] MASK_RESET = 9'd135;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 4 * OUT_W + DEG_W;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_TRY_CHARGE   = 3'd0;
    localparam action_t ACT_CHARGE       = 3'd1;
    localparam action_t ACT_CREDIT       = 3'd2;
    localparam action_t ACT_NOTE_DEGRADE = 3'd3;
    localparam action_t ACT_CLEAR_MINTED = 3'd4;
    localparam action_t ACT_CLEAR_ALL    = 3'd5;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_BUDGET_BYTES   = 2'd0;
    localparam cfg_index_t REG_BUDGET_ENABLED = 2'd1;
    localparam cfg_index_t REG_GATED_TAG_MASK = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/tagged_memory_budget_ledger_unit.sv -----
// Top level of the memory budget ledger: counters, budget check and output buffer.
// A result is registered in the output buffer when its transaction is accepted.
// Throughput: one transaction per cycle while s_tready is high; the counter update is
// a single add or subtract with a compare done in the accepting cycle.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset (aresetn low, synchronous) clears all counters, the output buffer and sets
// the configuration registers to their reset values (gate mask covers tags 0, 1, 2, 7).
`default_nettype none

module tagged_memory_budget_ledger_unit #(
    parameter int TAG_COUNT   = 9,
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_wr_en,
    input  wire logic [tmbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmbl_pkg::REG_W-1:0]      cfg_wdata,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: bytes[39:0], tag[43:40], zero fill.
    input  wire logic [tmbl_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: action[2:0].
    input  wire logic [tmbl_pkg::ACTION_W-1:0]   s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: live_total[47:0], gated_live[95:48], tag_live[143:96],
    // minted_since_sample[191:144], degrade_count[223:192].
    output logic [tmbl_pkg::M_TDATA_W-1:0]       m_tdata,
    // Fields from bit 0: granted[0].
    output logic                                 m_tuser
);

    localparam int TAG_W = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int SUM_W = ((COUNT_WIDTH > tmbl_pkg::BYTES_W) ? COUNT_WIDTH
                                                             : tmbl_pkg::BYTES_W) + 1;
    localparam int CMP_W = ((COUNT_WIDTH > tmbl_pkg::REG_W) ? COUNT_WIDTH
                                                           : tmbl_pkg::REG_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [tmbl_pkg::DEG_W-1:0] DEG_MAX = {tmbl_pkg::DEG_W{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Configuration registers.
    logic [tmbl_pkg::REG_W-1:0]  budget_bytes_reg;
    logic                        budget_enabled_reg;
    logic [tmbl_pkg::MASK_W-1:0] gated_tag_mask_reg;

    // Ledger counters.
    count_t                      total_live_reg, total_live_next;
    count_t                      gated_total_reg, gated_total_next;
    count_t                      per_tag_live_reg [TAG_COUNT];
    count_t                      tag_live_next;
    count_t                      minted_bytes_reg, minted_bytes_next;
    logic [tmbl_pkg::DEG_W-1:0]  degrade_events_reg, degrade_events_next;

    // Output buffer: a main register and a skid register.
    logic                            m_tvalid_reg;
    logic [tmbl_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                            m_tuser_reg;
    logic                            skid_valid_reg;
    logic [tmbl_pkg::M_TDATA_W-1:0]  skid_tdata_reg;
    logic                            skid_tuser_reg;

    tmbl_pkg::action_t               action;
    logic [tmbl_pkg::BYTES_W-1:0]    bytes;
    logic [tmbl_pkg::TAG_IN_W-1:0]   tag_in;
    logic [tmbl_pkg::TAG_IN_W-1:0]   tag_map;
    logic [TAG_W-1:0]                tag_idx;
    logic [15:0]                     mask_wide;
    logic                            gated;
    logic                            over_budget;
    logic                            granted;
    logic                            clear_all;
    logic                            s_accept;
    logic [tmbl_pkg::M_TDATA_W-1:0]  res_tdata;

    function automatic count_t sat_add(input count_t a,
                                       input logic [tmbl_pkg::BYTES_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return COUNT_WIDTH'(s);
    endfunction

    function automatic count_t clamp_sub(input count_t a,
                                         input logic [tmbl_pkg::BYTES_W-1:0] b);
        logic [SUM_W-1:0] wa;
        logic [SUM_W-1:0] wb;
        wa = SUM_W'(a);
        wb = SUM_W'(b);
        if (wa > wb) begin
            return COUNT_WIDTH'(wa - wb);
        end
        return '0;
    endfunction

    assign action = s_tuser;
    assign bytes  = s_tdata[tmbl_pkg::BYTES_W-1:0];
    assign tag_in = s_tdata[tmbl_pkg::BYTES_W +: tmbl_pkg::TAG_IN_W];

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // Tags past the last category fold onto the last one; tags without a mask
    // bit are never gated.
    assign tag_map   = ({1'b0, tag_in} >= 5'(TAG_COUNT)) ? 4'(TAG_COUNT - 1) : tag_in;
    assign tag_idx   = tag_map[TAG_W-1:0];
    assign mask_wide = 16'(gated_tag_mask_reg);
    assign gated     = mask_wide[tag_map];

    assign over_budget = (CMP_W'(gated_total_reg) + CMP_W'(bytes)) > CMP_W'(budget_bytes_reg);

    always_comb begin
        total_live_next     = total_live_reg;
        gated_total_next    = gated_total_reg;
        tag_live_next       = per_tag_live_reg[tag_idx];
        minted_bytes_next   = minted_bytes_reg;
        degrade_events_next = degrade_events_reg;
        granted             = 1'b1;
        clear_all           = 1'b0;
        case (action) inside
            tmbl_pkg::ACT_TRY_CHARGE, tmbl_pkg::ACT_CHARGE: begin
                if (bytes != '0) begin
                    if (action == tmbl_pkg::ACT_TRY_CHARGE && gated && budget_enabled_reg
                        && over_budget) begin
                        granted = 1'b0;
                    end else begin
                        total_live_next   = sat_add(total_live_reg, bytes);
                        tag_live_next     = sat_add(per_tag_live_reg[tag_idx], bytes);
                        minted_bytes_next = sat_add(minted_bytes_reg, bytes);
                        if (gated) begin
                            gated_total_next = sat_add(gated_total_reg, bytes);
                        end
                    end
                end
            end
            tmbl_pkg::ACT_CREDIT: begin
                if (bytes != '0) begin
                    total_live_next = clamp_sub(total_live_reg, bytes);
                    tag_live_next   = clamp_sub(per_tag_live_reg[tag_idx], bytes);
                    if (gated) begin
                        gated_total_next = clamp_sub(gated_total_reg, bytes);
                    end
                end
            end
            tmbl_pkg::ACT_NOTE_DEGRADE: begin
                if (degrade_events_reg != DEG_MAX) begin
                    degrade_events_next = degrade_events_reg + 1'b1;
                end
            end
            tmbl_pkg::ACT_CLEAR_MINTED: begin
                minted_bytes_next = '0;
            end
            tmbl_pkg::ACT_CLEAR_ALL: begin
                clear_all           = 1'b1;
                total_live_next     = '0;
                gated_total_next    = '0;
                tag_live_next       = '0;
                minted_bytes_next   = '0;
                degrade_events_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign res_tdata = {degrade_events_next,
                        tmbl_pkg::OUT_W'(minted_bytes_next),
                        tmbl_pkg::OUT_W'(tag_live_next),
                        tmbl_pkg::OUT_W'(gated_total_next),
                        tmbl_pkg::OUT_W'(total_live_next)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_bytes_reg   <= '0;
            budget_enabled_reg <= 1'b0;
            gated_tag_mask_reg <= tmbl_pkg::MASK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tmbl_pkg::REG_BUDGET_BYTES:   budget_bytes_reg   <= cfg_wdata;
                tmbl_pkg::REG_BUDGET_ENABLED: budget_enabled_reg <= cfg_wdata[0];
                tmbl_pkg::REG_GATED_TAG_MASK: begin
                    gated_tag_mask_reg <= cfg_wdata[tmbl_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_live_reg     <= '0;
            gated_total_reg    <= '0;
            minted_bytes_reg   <= '0;
            degrade_events_reg <= '0;
            for (int i = 0; i < TAG_COUNT; i++) begin
                per_tag_live_reg[i] <= '0;
            end
        end else if (s_accept) begin
            total_live_reg     <= total_live_next;
            gated_total_reg    <= gated_total_next;
            minted_bytes_reg   <= minted_bytes_next;
            degrade_events_reg <= degrade_events_next;
            if (clear_all) begin
                for (int i = 0; i < TAG_COUNT; i++) begin
                    per_tag_live_reg[i] <= '0;
                end
            end else begin
                per_tag_live_reg[tag_idx] <= tag_live_next;
            end
        end
    end

    // A new result goes to the main register when it is free or drains this
    // cycle, otherwise it parks in the skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_tvalid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    m_tvalid_reg   <= 1'b1;
                    m_tdata_reg    <= skid_tdata_reg;
                    m_tuser_reg    <= skid_tuser_reg;
                    skid_valid_reg <= 1'b0;
                end else if (s_accept) begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= res_tdata;
                    m_tuser_reg  <= granted;
                end else begin
                    m_tvalid_reg <= 1'b0;
                end
            end else if (s_accept) begin
                skid_valid_reg <= 1'b1;
                skid_tdata_reg <= res_tdata;
                skid_tuser_reg <= granted;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The skid register only fills behind a waiting result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid register holds a result while the output is empty");

    // An accepted clear_all leaves the total, gated, minted and degrade counters at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && action == tmbl_pkg::ACT_CLEAR_ALL |=>
            total_live_reg == '0 && gated_total_reg == '0 &&
            minted_bytes_reg == '0 && degrade_events_reg == '0)
        else $error("clear_all left a counter nonzero");

    // A refused try_charge must not move the live total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !granted |=> $stable(total_live_reg))
        else $error("refused charge changed the live total");

endmodule

`default_nettype wire

// ----- tb/tagged_memory_budget_ledger_unit_test.sv -----
// Self-checking testbench for the tagged memory budget ledger unit.
`default_nettype none

module tagged_memory_budget_ledger_unit_test;

    localparam int LEDGER_TAGS = 9;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam tmbl_pkg::action_t ACT_SPARE_6 = 3'd6;
    localparam tmbl_pkg::action_t ACT_SPARE_7 = 3'd7;
    localparam logic [tmbl_pkg::BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [tmbl_pkg::REG_W-1:0] COUNT_MAX = '1;
    localparam logic [tmbl_pkg::MASK_W-1:0] MASK_ALL = '1;

    typedef struct packed {
        tmbl_pkg::action_t                 action;
        logic [tmbl_pkg::BYTES_W-1:0]      bytes;
        logic [tmbl_pkg::TAG_IN_W-1:0]     tag;
    } ledger_op_t;

    typedef struct packed {
        logic                        granted;
        logic [tmbl_pkg::OUT_W-1:0]  live_total;
        logic [tmbl_pkg::OUT_W-1:0]  gated_live;
        logic [tmbl_pkg::OUT_W-1:0]  tag_live;
        logic [tmbl_pkg::OUT_W-1:0]  minted;
        logic [tmbl_pkg::DEG_W-1:0]  degrade;
    } ledger_report_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [tmbl_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [tmbl_pkg::REG_W-1:0]        cfg_wdata = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [tmbl_pkg::S_TDATA_W-1:0]    s_tdata = '0;
    logic [tmbl_pkg::ACTION_W-1:0]     s_tuser = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [tmbl_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                              m_tuser;

    tagged_memory_budget_ledger_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ledger_op_t     pending_ops[$];
    ledger_report_t expected_reports[$];

    // Predictor copy of the configuration and the counters.
    logic [tmbl_pkg::REG_W-1:0]  budget_cfg;
    logic                        enable_cfg;
    logic [tmbl_pkg::MASK_W-1:0] mask_cfg;
    logic [tmbl_pkg::REG_W-1:0]  live_sum;
    logic [tmbl_pkg::REG_W-1:0]  gated_sum;
    logic [tmbl_pkg::REG_W-1:0]  tag_sum[LEDGER_TAGS];
    logic [tmbl_pkg::REG_W-1:0]  minted_sum;
    logic [tmbl_pkg::DEG_W-1:0]  degrade_events;

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          calm_tail = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned recv_hold = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [tmbl_pkg::REG_W-1:0] sat_add(
        logic [tmbl_pkg::REG_W-1:0] a, logic [tmbl_pkg::BYTES_W-1:0] b);
        logic [tmbl_pkg::REG_W:0] s;
        s = (tmbl_pkg::REG_W+1)'(a) + (tmbl_pkg::REG_W+1)'(b);
        return s[tmbl_pkg::REG_W] ? COUNT_MAX : s[tmbl_pkg::REG_W-1:0];
    endfunction

    function automatic logic [tmbl_pkg::REG_W-1:0] floor_sub(
        logic [tmbl_pkg::REG_W-1:0] a, logic [tmbl_pkg::BYTES_W-1:0] b);
        return (a > tmbl_pkg::REG_W'(b)) ? a - tmbl_pkg::REG_W'(b) : '0;
    endfunction

    function automatic void clear_ledger();
        live_sum = '0;
        gated_sum = '0;
        for (int i = 0; i < LEDGER_TAGS; i++) tag_sum[i] = '0;
        minted_sum = '0;
        degrade_events = '0;
    endfunction

    // Predictor: applies register writes and accepted transactions in edge order.
    always @(posedge aclk) begin : ledger_model
        ledger_op_t     op;
        ledger_report_t rep;
        int             slot;
        logic           gate_hit;
        logic           refused;
        if (!aresetn) begin
            budget_cfg = '0;
            enable_cfg = 1'b0;
            mask_cfg = tmbl_pkg::MASK_RESET;
            clear_ledger();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tmbl_pkg::REG_BUDGET_BYTES:   budget_cfg = cfg_wdata;
                    tmbl_pkg::REG_BUDGET_ENABLED: enable_cfg = cfg_wdata[0];
                    tmbl_pkg::REG_GATED_TAG_MASK: mask_cfg = cfg_wdata[tmbl_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                op.action = s_tuser;
                op.bytes = s_tdata[tmbl_pkg::BYTES_W-1:0];
                op.tag = s_tdata[tmbl_pkg::BYTES_W +: tmbl_pkg::TAG_IN_W];
                slot = (op.tag >= LEDGER_TAGS) ? LEDGER_TAGS - 1 : int'(op.tag);
                gate_hit = mask_cfg[slot];
                refused = 1'b0;
                case (op.action)
                    tmbl_pkg::ACT_TRY_CHARGE, tmbl_pkg::ACT_CHARGE: begin
                        if (op.bytes != 0) begin
                            if (op.action == tmbl_pkg::ACT_TRY_CHARGE && gate_hit && enable_cfg)
                                refused = (tmbl_pkg::REG_W'(op.bytes) > budget_cfg) ||
                                          (gated_sum > budget_cfg -
                                                       tmbl_pkg::REG_W'(op.bytes));
                            if (!refused) begin
                                live_sum = sat_add(live_sum, op.bytes);
                                tag_sum[slot] = sat_add(tag_sum[slot], op.bytes);
                                minted_sum = sat_add(minted_sum, op.bytes);
                                if (gate_hit) gated_sum = sat_add(gated_sum, op.bytes);
                            end
                        end
                    end
                    tmbl_pkg::ACT_CREDIT: begin
                        // Each counter clamps at zero independently of the others.
                        live_sum = floor_sub(live_sum, op.bytes);
                        tag_sum[slot] = floor_sub(tag_sum[slot], op.bytes);
                        if (gate_hit) gated_sum = floor_sub(gated_sum, op.bytes);
                    end
                    tmbl_pkg::ACT_NOTE_DEGRADE: begin
                        if (degrade_events != '1) degrade_events = degrade_events + 1'b1;
                    end
                    tmbl_pkg::ACT_CLEAR_MINTED: minted_sum = '0;
                    tmbl_pkg::ACT_CLEAR_ALL:    clear_ledger();
                    default: ;
                endcase
                rep.granted = ~refused;
                rep.live_total = live_sum;
                rep.gated_live = gated_sum;
                rep.tag_live = tag_sum[slot];
                rep.minted = minted_sum;
                rep.degrade = degrade_events;
                expected_reports.push_back(rep);
            end
        end
    end

    // Input driver: offers queued operations with random idle bursts.
    always @(posedge aclk) begin : op_driver
        ledger_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!calm_tail && pending_ops.size() > 0 &&
                         $urandom_range(0, 99) < 6) begin
                send_gap = $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(tmbl_pkg::S_TDATA_W - tmbl_pkg::BYTES_W - tmbl_pkg::TAG_IN_W){1'b0}},
                            op.tag, op.bytes};
                s_tuser <= op.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side ready: random stall bursts plus an occasional long hold-off.
    always @(posedge aclk) begin : ready_driver
        logic ready_next;
        if (long_hold_req) begin
            recv_hold = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (!aresetn) begin
            ready_next = 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            ready_next = 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            ready_next = 1'b0;
        end else if (!calm_tail && $urandom_range(0, 99) < 8) begin
            recv_stall = $urandom_range(1, 19) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    always @(posedge aclk) begin : report_check
        ledger_report_t got;
        ledger_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.granted = m_tuser;
            got.live_total = m_tdata[0 +: tmbl_pkg::OUT_W];
            got.gated_live = m_tdata[tmbl_pkg::OUT_W +: tmbl_pkg::OUT_W];
            got.tag_live = m_tdata[2*tmbl_pkg::OUT_W +: tmbl_pkg::OUT_W];
            got.minted = m_tdata[3*tmbl_pkg::OUT_W +: tmbl_pkg::OUT_W];
            got.degrade = m_tdata[4*tmbl_pkg::OUT_W +: tmbl_pkg::DEG_W];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: granted=%0d live=%0h gated=%0h",
                             got.granted, got.live_total, got.gated_live);
            end else begin
                want = expected_reports.pop_front();
                if (got.granted !== want.granted || got.live_total !== want.live_total ||
                    got.gated_live !== want.gated_live || got.tag_live !== want.tag_live ||
                    got.minted !== want.minted || got.degrade !== want.degrade) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected granted=%0d live=%0h gated=%0h tag=%0h",
                                 want.granted, want.live_total, want.gated_live, want.tag_live);
                        $display("          minted=%0h degrade=%0h", want.minted, want.degrade);
                        $display("          actual granted=%0d live=%0h gated=%0h tag=%0h",
                                 got.granted, got.live_total, got.gated_live, got.tag_live);
                        $display("          minted=%0h degrade=%0h", got.minted, got.degrade);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL tagged_memory_budget_ledger_unit");
            $finish;
        end
    end

    task automatic queue_op(tmbl_pkg::action_t action, logic [tmbl_pkg::BYTES_W-1:0] bytes,
                            logic [tmbl_pkg::TAG_IN_W-1:0] tag);
        ledger_op_t op;
        op.action = action;
        op.bytes = bytes;
        op.tag = tag;
        pending_ops.push_back(op);
    endtask

    function automatic ledger_op_t random_op(logic [63:0] magnitude);
        ledger_op_t op;
        logic [63:0] wide;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      op.action = tmbl_pkg::ACT_TRY_CHARGE;
        else if (pick < 50) op.action = tmbl_pkg::ACT_CHARGE;
        else if (pick < 78) op.action = tmbl_pkg::ACT_CREDIT;
        else if (pick < 86) op.action = tmbl_pkg::ACT_NOTE_DEGRADE;
        else if (pick < 91) op.action = tmbl_pkg::ACT_CLEAR_MINTED;
        else if (pick < 94) op.action = tmbl_pkg::ACT_CLEAR_ALL;
        else                op.action = ($urandom_range(0, 1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 4)       op.bytes = '0;
        else if (pick < 10) op.bytes = wide[tmbl_pkg::BYTES_W-1:0];
        else if (pick < 13) op.bytes = BYTES_MAX;
        else                op.bytes = tmbl_pkg::BYTES_W'(wide % magnitude + 64'd1);
        op.tag = ($urandom_range(0, 99) < 80) ? tmbl_pkg::TAG_IN_W'($urandom_range(0, 8))
                                              : tmbl_pkg::TAG_IN_W'($urandom_range(9, 15));
        return op;
    endfunction

    task automatic queue_random(int count, logic [63:0] magnitude);
        repeat (count) pending_ops.push_back(random_op(magnitude));
    endtask

    task automatic write_reg(tmbl_pkg::cfg_index_t idx, logic [tmbl_pkg::REG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_ledger(logic [tmbl_pkg::REG_W-1:0] budget, logic enable,
                                  logic [tmbl_pkg::MASK_W-1:0] mask);
        write_reg(tmbl_pkg::REG_BUDGET_BYTES, budget);
        write_reg(tmbl_pkg::REG_BUDGET_ENABLED, {{(tmbl_pkg::REG_W-1){1'b0}}, enable});
        write_reg(tmbl_pkg::REG_GATED_TAG_MASK,
                  {{(tmbl_pkg::REG_W-tmbl_pkg::MASK_W){1'b0}}, mask});
    endtask

    // Blocks the stimulus until every queued operation has been answered.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_reports.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [63:0]                    wide;
        logic [tmbl_pkg::TAG_IN_W-1:0]  tag;
        logic [tmbl_pkg::BYTES_W-1:0]   bytes;
        int unsigned                    pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: budget disabled, default gate mask.
        queue_op(tmbl_pkg::ACT_CHARGE, '0, 4'd0);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd1000, 4'd0);
        queue_op(tmbl_pkg::ACT_CHARGE, BYTES_MAX, 4'd15);
        queue_op(tmbl_pkg::ACT_CHARGE, 40'd300, 4'd9);
        queue_op(tmbl_pkg::ACT_CREDIT, 40'd5000, 4'd1);
        queue_op(tmbl_pkg::ACT_NOTE_DEGRADE, '0, 4'd0);
        queue_op(tmbl_pkg::ACT_NOTE_DEGRADE, 40'h5A_A5A5_5A5A, 4'd3);
        queue_op(tmbl_pkg::ACT_CLEAR_MINTED, '0, 4'd8);
        queue_op(ACT_SPARE_6, 40'd77, 4'd2);
        queue_op(ACT_SPARE_7, BYTES_MAX, 4'd12);
        queue_op(tmbl_pkg::ACT_CLEAR_ALL, '0, 4'd0);
        wait_drained();

        program_ledger(48'd1000, 1'b1, tmbl_pkg::MASK_RESET);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd500, 4'd0);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd600, 4'd7);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd500, 4'd2);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd1, 4'd1);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, BYTES_MAX, 4'd3);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, '0, 4'd0);
        queue_op(tmbl_pkg::ACT_CHARGE, 40'd100, 4'd0);
        queue_op(tmbl_pkg::ACT_CREDIT, 40'd2000, 4'd2);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd2000, 4'd7);
        queue_op(tmbl_pkg::ACT_TRY_CHARGE, 40'd5, 4'd14);
        queue_op(tmbl_pkg::ACT_CREDIT, '0, 4'd5);
        queue_op(tmbl_pkg::ACT_CLEAR_ALL, '0, 4'd0);
        wait_drained();

        program_ledger(48'd5000, 1'b1, tmbl_pkg::MASK_RESET);
        queue_random(300, 64'd1200);
        wait_drained();

        // Full budget with every tag gated; near-maximal charges drive the
        // counters into saturation.
        program_ledger(COUNT_MAX, 1'b1, MASK_ALL);
        repeat (380) begin
            pick = $urandom_range(0, 99);
            tag = ($urandom_range(0, 3) != 0) ? tmbl_pkg::TAG_IN_W'($urandom_range(8, 15))
                                              : tmbl_pkg::TAG_IN_W'($urandom_range(0, 7));
            bytes = BYTES_MAX - tmbl_pkg::BYTES_W'($urandom_range(0, 3));
            if (pick < 90)      queue_op(tmbl_pkg::ACT_CHARGE, bytes, tag);
            else if (pick < 96) queue_op(tmbl_pkg::ACT_TRY_CHARGE, bytes, tag);
            else                queue_op(tmbl_pkg::ACT_CREDIT, bytes, tag);
        end
        queue_random(20, {24'd0, BYTES_MAX});
        wait_drained();

        // Zero budget; the result side holds off long enough to back up the input.
        program_ledger('0, 1'b1, tmbl_pkg::MASK_W'($urandom_range(0, 511)));
        queue_random(200, 64'd1000);
        long_hold_req = 1'b1;
        wait_drained();

        wide = {$urandom, $urandom};
        program_ledger(wide[tmbl_pkg::REG_W-1:0], 1'b1, '0);
        queue_random(250, 64'd1 << 36);
        wait_drained();

        wide = {$urandom, $urandom};
        program_ledger({28'd0, wide[19:0]}, 1'b0, tmbl_pkg::MASK_W'($urandom_range(0, 511)));
        queue_random(250, 64'd1 << 18);
        wait_drained();

        calm_tail = 1'b1;
        program_ledger(48'd3000, 1'b1, tmbl_pkg::MASK_W'($urandom_range(0, 511)));
        queue_random(280, 64'd800);
        wait_drained();

        repeat (4) @(negedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("PASS tagged_memory_budget_ledger_unit");
        end else begin
            $display("FAIL tagged_memory_budget_ledger_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
